@@ sv/assert_macros.svh @@
// Assertion macros used by the converter's top level.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ITP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ITP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/itp_pkg.sv @@
// Package for the infix to postfix converter: sizes, codes, types and
// small decode functions. Depends on nothing.
package itp_pkg;

  // Operator stack size and derived widths.
  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Queue between the front and the back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Result kinds.
  localparam logic [2:0] KIND_OPERAND = 3'd0;
  localparam logic [2:0] KIND_BINARY  = 3'd1;
  localparam logic [2:0] KIND_UNARY   = 3'd2;
  localparam logic [2:0] KIND_END     = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;

  // Operator codes held on the stack.
  localparam logic [2:0] OPC_NONE  = 3'd0;
  localparam logic [2:0] OPC_OPEN  = 3'd1;
  localparam logic [2:0] OPC_PLUS  = 3'd2;
  localparam logic [2:0] OPC_MINUS = 3'd3;
  localparam logic [2:0] OPC_MUL   = 3'd4;
  localparam logic [2:0] OPC_DIV   = 3'd5;
  localparam logic [2:0] OPC_POW   = 3'd6;

  // Class of a character as seen by the back.
  typedef enum logic [2:0] {
    CLS_END,
    CLS_OPERAND,
    CLS_CLOSE,
    CLS_OPEN,
    CLS_OPER
  } cls_e;

  // One stack entry: unary flag and operator code.
  typedef struct packed {
    logic       unary;
    logic [2:0] opc;
  } entry_t;

  // Classified character passed from the front to the back.
  typedef struct packed {
    cls_e       cls;
    logic [7:0] ch;
    logic       start;
    entry_t     ent;
  } cmd_t;

  // Status of the back, watched at the top level.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             err;
  } bk_stat_t;

  // Operator code of a character, OPC_NONE when it is no operator.
  function automatic logic [2:0] op_code(input logic [7:0] c);
    logic [2:0] r;
    unique case (c)
      CH_OPEN:  r = OPC_OPEN;
      CH_PLUS:  r = OPC_PLUS;
      CH_MINUS: r = OPC_MINUS;
      CH_MUL:   r = OPC_MUL;
      CH_DIV:   r = OPC_DIV;
      CH_POW:   r = OPC_POW;
      default:  r = OPC_NONE;
    endcase
    return r;
  endfunction

  // Character of an operator code.
  function automatic logic [7:0] opc_char(input logic [2:0] opc);
    logic [7:0] r;
    unique case (opc)
      OPC_OPEN:  r = CH_OPEN;
      OPC_PLUS:  r = CH_PLUS;
      OPC_MINUS: r = CH_MINUS;
      OPC_MUL:   r = CH_MUL;
      OPC_DIV:   r = CH_DIV;
      OPC_POW:   r = CH_POW;
      default:   r = CH_NUL;
    endcase
    return r;
  endfunction

  // Priority of an operator code; the open paren is lowest.
  function automatic logic [2:0] opc_prio(input logic [2:0] opc);
    logic [2:0] r;
    unique case (opc)
      OPC_PLUS, OPC_MINUS: r = 3'd2;
      OPC_MUL, OPC_DIV:    r = 3'd3;
      OPC_POW:             r = 3'd4;
      default:             r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/itp_if.sv @@
// Channel interfaces of the converter: the symbol input and the token output.
// Depends on nothing.
interface itp_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface itp_tok_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] token_char;
  logic       token_start;
  logic       last_of_run;

  modport source (output valid, output token_kind, output token_char,
                  output token_start, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_char,
                  input token_start, input last_of_run, output ready);
endinterface

@@ sv/itp_front.sv @@
// Front of the converter: accepts symbols, classifies them and tracks the
// operand and unary context. Depends on itp_pkg and itp_sym_if.
module itp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  itp_sym_if.sink        sym_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output itp_pkg::cmd_t  q_data_o
);
  import itp_pkg::*;

  logic [7:0] prev_q, prev_d;
  logic       seen_q, seen_d;
  logic       inside_q, inside_d;
  logic [2:0] opc;
  logic       is_delim;
  logic       accept;

  assign sym_i.ready = !q_full_i;
  assign accept      = sym_i.valid && sym_i.ready;
  assign opc         = op_code(sym_i.symbol);
  assign is_delim    = (sym_i.symbol == CH_SPACE) || (sym_i.symbol == CH_NL);
  assign q_push_o    = accept && !is_delim;

  // Classify the symbol; a plus or minus is unary at the start of the
  // expression or after any operator other than a close paren.
  always_comb begin
    q_data_o.ch        = sym_i.symbol;
    q_data_o.start     = !inside_q;
    q_data_o.ent.opc   = opc;
    q_data_o.ent.unary = ((opc == OPC_PLUS) || (opc == OPC_MINUS)) &&
                         (!seen_q || (op_code(prev_q) != OPC_NONE));
    if (sym_i.symbol == CH_NUL) begin
      q_data_o.cls = CLS_END;
    end else if (sym_i.symbol == CH_CLOSE) begin
      q_data_o.cls = CLS_CLOSE;
    end else if (opc == OPC_OPEN) begin
      q_data_o.cls = CLS_OPEN;
    end else if (opc != OPC_NONE) begin
      q_data_o.cls = CLS_OPER;
    end else begin
      q_data_o.cls = CLS_OPERAND;
    end
  end

  // Context update for each accepted transaction.
  always_comb begin
    prev_d   = prev_q;
    seen_d   = seen_q;
    inside_d = inside_q;
    if (accept) begin
      if (sym_i.symbol == CH_NUL) begin
        prev_d   = CH_NUL;
        seen_d   = 1'b0;
        inside_d = 1'b0;
      end else if (is_delim) begin
        inside_d = 1'b0;
      end else begin
        prev_d   = sym_i.symbol;
        seen_d   = 1'b1;
        inside_d = (opc == OPC_NONE) && (sym_i.symbol != CH_CLOSE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= CH_NUL;
      seen_q   <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      prev_q   <= prev_d;
      seen_q   <= seen_d;
      inside_q <= inside_d;
    end
  end

endmodule

@@ sv/itp_queue.sv @@
// Short queue of classified symbols between the front and the back.
// Depends on itp_pkg.
module itp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  itp_pkg::cmd_t  data_i,
  output logic           full_o,
  input  logic           pop_i,
  output itp_pkg::cmd_t  data_o,
  output logic           empty_o
);
  import itp_pkg::*;

  cmd_t               slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ sv/itp_back.sv @@
// Back of the converter: runs the operator stack and produces the tokens
// into an output register. Depends on itp_pkg and itp_tok_if.
module itp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  itp_pkg::cmd_t     q_data_i,
  output logic              q_pop_o,
  itp_tok_if.source         tok_o,
  output itp_pkg::bk_stat_t stat_o
);
  import itp_pkg::*;

  // Stack: top entry and the one below it in registers, the rest in memory.
  entry_t           mem_q [STACK_DEPTH];
  entry_t           top_q, sec_q;
  logic [CNT_W-1:0] cnt_q;
  logic             err_q;
  logic [CNT_W-1:0] rd_idx, wr_idx;

  // Output register.
  logic       out_valid_q;
  logic [2:0] out_kind_q;
  logic [7:0] out_char_q;
  logic       out_start_q;
  logic       out_last_q;

  cmd_t       head;
  logic       can_emit, fire;
  logic       cnt_nz, cnt_ge2, stk_full;
  logic [2:0] prio;
  logic       is_pow, top_pop, sec_pop;
  logic       em, em_start, em_last;
  logic [2:0] em_kind;
  logic [7:0] em_char;
  logic       do_pop, do_push, do_clear, set_err, done;

  assign head     = q_data_i;
  assign can_emit = !out_valid_q || tok_o.ready;
  assign cnt_nz   = (cnt_q != '0);
  assign cnt_ge2  = (cnt_q >= CNT_W'(2));
  assign stk_full = (cnt_q == CNT_W'(STACK_DEPTH));
  assign prio     = opc_prio(head.ent.opc);
  assign is_pow   = (head.ent.opc == OPC_POW);
  assign top_pop  = is_pow ? (opc_prio(top_q.opc) > prio) : (opc_prio(top_q.opc) >= prio);
  assign sec_pop  = is_pow ? (opc_prio(sec_q.opc) > prio) : (opc_prio(sec_q.opc) >= prio);
  assign rd_idx   = cnt_q - CNT_W'(3);
  assign wr_idx   = cnt_q - CNT_W'(1);

  // One step of the item at the queue head; pops take one step each.
  always_comb begin
    em       = 1'b0;
    em_kind  = KIND_ERROR;
    em_char  = CH_NUL;
    em_start = 1'b1;
    em_last  = 1'b1;
    do_pop   = 1'b0;
    do_push  = 1'b0;
    do_clear = 1'b0;
    set_err  = 1'b0;
    done     = 1'b0;
    if (err_q && (head.cls != CLS_END)) begin
      done = 1'b1;
    end else begin
      unique case (head.cls)
        CLS_END: begin
          if (err_q || !cnt_nz) begin
            em       = 1'b1;
            em_kind  = KIND_END;
            do_clear = 1'b1;
            done     = 1'b1;
          end else if (top_q.opc == OPC_OPEN) begin
            do_pop = 1'b1;
          end else begin
            em      = 1'b1;
            em_kind = top_q.unary ? KIND_UNARY : KIND_BINARY;
            em_char = opc_char(top_q.opc);
            em_last = 1'b0;
            do_pop  = 1'b1;
          end
        end
        CLS_OPERAND: begin
          em       = 1'b1;
          em_kind  = KIND_OPERAND;
          em_char  = head.ch;
          em_start = head.start;
          done     = 1'b1;
        end
        CLS_CLOSE: begin
          if (!cnt_nz) begin
            em      = 1'b1;
            set_err = 1'b1;
            done    = 1'b1;
          end else if (top_q.opc == OPC_OPEN) begin
            do_pop = 1'b1;
            done   = 1'b1;
          end else begin
            // Last result only when the matching open paren lies just below.
            em      = 1'b1;
            em_kind = top_q.unary ? KIND_UNARY : KIND_BINARY;
            em_char = opc_char(top_q.opc);
            em_last = cnt_ge2 && (sec_q.opc == OPC_OPEN);
            do_pop  = 1'b1;
          end
        end
        CLS_OPEN: begin
          if (stk_full) begin
            em      = 1'b1;
            set_err = 1'b1;
          end else begin
            do_push = 1'b1;
          end
          done = 1'b1;
        end
        CLS_OPER: begin
          if (cnt_nz && top_pop) begin
            // After a pop the push always fits, so no error can follow.
            em      = 1'b1;
            em_kind = top_q.unary ? KIND_UNARY : KIND_BINARY;
            em_char = opc_char(top_q.opc);
            em_last = !(cnt_ge2 && sec_pop);
            do_pop  = 1'b1;
          end else if (stk_full) begin
            em      = 1'b1;
            set_err = 1'b1;
            done    = 1'b1;
          end else begin
            do_push = 1'b1;
            done    = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  assign fire    = !q_empty_i && (!em || can_emit);
  assign q_pop_o = fire && done;

  // Stack count and error flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      err_q <= 1'b0;
    end else if (fire) begin
      if (do_clear) begin
        cnt_q <= '0;
        err_q <= 1'b0;
      end else begin
        if (do_pop) begin
          cnt_q <= cnt_q - 1'b1;
        end else if (do_push) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (set_err) begin
          err_q <= 1'b1;
        end
      end
    end
  end

  // Top registers and the stack memory, one read or one write a cycle.
  always_ff @(posedge clk_i) begin
    if (fire && do_push) begin
      top_q <= head.ent;
      sec_q <= top_q;
      if (cnt_nz) begin
        mem_q[wr_idx[PTR_W-1:0]] <= top_q;
      end
    end else if (fire && do_pop) begin
      top_q <= sec_q;
      sec_q <= mem_q[rd_idx[PTR_W-1:0]];
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && em) begin
      out_valid_q <= 1'b1;
    end else if (tok_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (fire && em) begin
      out_kind_q  <= em_kind;
      out_char_q  <= em_char;
      out_start_q <= em_start;
      out_last_q  <= em_last;
    end
  end

  assign tok_o.valid       = out_valid_q;
  assign tok_o.token_kind  = out_kind_q;
  assign tok_o.token_char  = out_char_q;
  assign tok_o.token_start = out_start_q;
  assign tok_o.last_of_run = out_last_q;

  assign stat_o.cnt = cnt_q;
  assign stat_o.err = err_q;

endmodule

@@ sv/infix_to_postfix_converter_unit.sv @@
// Top level of the infix to postfix converter: front, queue and back.
// Depends on itp_pkg, itp_if.sv, itp_front, itp_queue, itp_back, assert_macros.svh.
//
//  channel  dir  payload                                        transaction
//  sym_i    in   symbol[7:0]                                    valid && ready
//  tok_o    out  token_kind[2:0] token_char[7:0] token_start
//                last_of_run                                    valid && ready
//
// The back gives each operator popped by a close paren or an operator, and
// each stack entry flushed at the end of the expression, a step of its own;
// the matching open paren leaves in the close paren's own step. The single
// port of the stack memory sets this pace. Space and
// newline end in the front. Reset is asynchronous and needs no clearing pass;
// only stack entries below the fill count are ever used. Front and back stall
// on their own through the two-entry queue, and the back stalls only while
// the output register holds a token that has not been taken.
`include "assert_macros.svh"

module infix_to_postfix_converter_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  itp_sym_if.sink    sym_i,
  itp_tok_if.source  tok_o
);
  import itp_pkg::*;

  logic     q_push, q_pop, q_full, q_empty;
  cmd_t     q_wr_data, q_rd_data;
  bk_stat_t stat;

  itp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sym_i    (sym_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wr_data)
  );

  itp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rd_data),
    .empty_o (q_empty)
  );

  itp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rd_data),
    .q_pop_o   (q_pop),
    .tok_o     (tok_o),
    .stat_o    (stat)
  );

  // The stack never holds more entries than it has room for.
  `ITP_ASSERT(a_stack_bound, stat.cnt <= CNT_W'(STACK_DEPTH), "stack count out of range")

  // While an error is pending, the token on the output is the error itself.
  `ITP_ASSERT(a_err_token, stat.err && tok_o.valid |-> tok_o.token_kind == KIND_ERROR, "token after error")

  // The error clears only at the end of an expression, with the stack empty.
  `ITP_ASSERT(a_err_clear, $fell(stat.err) |-> stat.cnt == '0, "error cleared with stack in use")

endmodule
